// ===== hdl/sobel_edge_magnitude_macros.svh =====
// Assertion macros shared by the sobel_edge_magnitude RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SEM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sem_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude block.
// Used by sem_front, sem_queue, sem_back and sobel_edge_magnitude; depends on nothing.
package sem_pkg;

    localparam int PIX_W      = 8;
    localparam int MAG_W      = 8;
    localparam int OUT_X_W    = 10;
    localparam int OUT_Y_W    = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_DATA_W-1:0] CFG_WIDTH_RESET  = CFG_DATA_W'(1024);
    localparam logic [CFG_DATA_W-1:0] CFG_HEIGHT_RESET = CFG_DATA_W'(1024);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // Queue between front and back; depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One classified pixel: the new window column plus the reported position.
    typedef struct packed {
        logic [PIX_W-1:0]   up2;
        logic [PIX_W-1:0]   up1;
        logic [PIX_W-1:0]   pixel;
        logic [OUT_X_W-1:0] out_x;
        logic [OUT_Y_W-1:0] out_y;
        logic               border;
        logic               frame_end;
    } t_item;

    typedef struct packed {
        logic                valid;
        logic [QUEUE_CW-1:0] count;
    } t_q_stat;

endpackage

// ===== hdl/sem_front.sv =====
// Front end: configuration registers, raster position, line buffers.
// Classifies each pixel (reported position, border, frame end); uses sem_pkg.
module sem_front #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [sem_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_cfg_ready,
    input  logic                             i_push,
    input  logic [sem_pkg::PIX_W-1:0]        i_pixel,
    input  logic                             i_frame_start,
    output logic                             o_full,
    input  sem_pkg::t_q_stat                 i_q_stat,
    output logic                             o_push,
    output sem_pkg::t_item                   o_item
);
    import sem_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int SWW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int SHW = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
    localparam int LW  = 2 * PIX_W;

    logic [CFG_DATA_W-1:0] r_cfg_width;
    logic [CFG_DATA_W-1:0] r_cfg_height;
    logic [WW-1:0]         w_wd;
    logic [HW-1:0]         w_ht;

    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic [CW-1:0]         w_col;
    logic [RW-1:0]         w_row;
    logic [CW-1:0]         n_col;
    logic [RW-1:0]         n_row;
    logic [CW-1:0]         w_ox;
    logic [RW-1:0]         w_oy;
    logic signed [RW+1:0]  w_row_s;
    logic signed [RW+1:0]  w_ht_s;
    logic signed [RW+1:0]  w_dec;
    logic signed [RW+1:0]  w_t0;
    logic signed [RW+1:0]  w_t1;
    logic signed [RW+1:0]  w_t2;
    logic                  w_accept;
    logic [QUEUE_CW:0]     w_used;

    logic                  r_s1_valid;
    logic [CW-1:0]         r_addr;
    logic [PIX_W-1:0]      r_px;
    logic [CW-1:0]         r_ox;
    logic [RW-1:0]         r_oy;
    logic [LW-1:0]         r_rd;
    logic                  r_byp_valid;
    logic [CW-1:0]         r_byp_addr;
    logic [LW-1:0]         r_byp_data;
    logic [LW-1:0]         w_line;
    logic [LW-1:0]         w_wr_data;
    logic                  w_border;
    logic                  w_fend;

    // Each entry packs {older row, newer row} for one column.
    logic [LW-1:0]         r_lines [MAX_WIDTH];

    assign o_cfg_ready = 1'b1;

    // Reserve a queue slot for the item in flight.
    assign w_used   = (QUEUE_CW+1)'(i_q_stat.count) + (QUEUE_CW+1)'(r_s1_valid);
    assign o_full   = (w_used >= (QUEUE_CW+1)'(QUEUE_DEPTH));
    assign w_accept = i_push && !o_full;

    // Saturate sizes to 1..MAX.
    always_comb begin
        if (r_cfg_width == '0) begin
            w_wd = WW'(1);
        end else if (SWW'(r_cfg_width) > SWW'(MAX_WIDTH)) begin
            w_wd = WW'(MAX_WIDTH);
        end else begin
            w_wd = WW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            w_ht = HW'(1);
        end else if (SHW'(r_cfg_height) > SHW'(MAX_HEIGHT)) begin
            w_ht = HW'(MAX_HEIGHT);
        end else begin
            w_ht = HW'(r_cfg_height);
        end
    end

    // Current position, and the position W+1 earlier wrapped into the frame.
    always_comb begin
        w_col   = (i_frame_start || (WW'(r_col) >= w_wd)) ? '0 : r_col;
        w_row   = (i_frame_start || (HW'(r_row) >= w_ht)) ? '0 : r_row;
        w_ox    = (w_col == '0) ? CW'(w_wd - WW'(1)) : w_col - CW'(1);
        w_row_s = $signed((RW+2)'(w_row));
        w_ht_s  = $signed((RW+2)'(w_ht));
        w_dec   = (w_col == '0) ? (RW+2)'(2) : (RW+2)'(1);
        w_t0    = w_row_s - w_dec;
        w_t1    = w_t0[RW+1] ? w_t0 + w_ht_s : w_t0;
        w_t2    = w_t1[RW+1] ? w_t1 + w_ht_s : w_t1;
        w_oy    = w_t2[RW-1:0];
        if ((WW'(w_col) + WW'(1)) >= w_wd) begin
            n_col = '0;
            n_row = ((HW'(w_row) + HW'(1)) >= w_ht) ? '0 : w_row + RW'(1);
        end else begin
            n_col = w_col + CW'(1);
            n_row = w_row;
        end
    end

    // Forward the write that landed on the same edge as this read.
    assign w_line    = (r_byp_valid && (r_byp_addr == r_addr)) ? r_byp_data : r_rd;
    assign w_wr_data = {w_line[PIX_W-1:0], r_px};
    assign w_border  = (r_ox == '0) || (r_oy == '0) ||
                       ((WW'(r_ox) + WW'(1)) >= w_wd) || ((HW'(r_oy) + HW'(1)) >= w_ht);
    assign w_fend    = (WW'(r_ox) == (w_wd - WW'(1))) && (HW'(r_oy) == (w_ht - HW'(1)));

    assign o_push           = r_s1_valid;
    assign o_item.up2       = w_line[LW-1:PIX_W];
    assign o_item.up1       = w_line[PIX_W-1:0];
    assign o_item.pixel     = r_px;
    assign o_item.out_x     = OUT_X_W'(r_ox);
    assign o_item.out_y     = OUT_Y_W'(r_oy);
    assign o_item.border    = w_border;
    assign o_item.frame_end = w_fend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_WIDTH_RESET;
            r_cfg_height <= CFG_HEIGHT_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_s1_valid   <= 1'b0;
            r_byp_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1_valid  <= w_accept;
            r_byp_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr <= w_col;
            r_px   <= i_pixel;
            r_ox   <= w_ox;
            r_oy   <= w_oy;
        end
        r_byp_addr <= r_addr;
        r_byp_data <= w_wr_data;
    end

    // Line buffer: read at accept, write back in the following cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= r_lines[w_col];
        end
        if (r_s1_valid) begin
            r_lines[r_addr] <= w_wr_data;
        end
    end

endmodule

// ===== hdl/sem_queue.sv =====
// Short queue of classified pixels between the front end and the back end.
// Uses sem_pkg types and the assertion macros header.
`include "sobel_edge_magnitude_macros.svh"

module sem_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sem_pkg::t_item   i_item,
    input  logic             i_pop,
    output sem_pkg::t_item   o_item,
    output sem_pkg::t_q_stat o_stat
);
    import sem_pkg::*;

    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_CW-1:0] r_cnt;
    logic                w_pop;
    t_item               r_mem [QUEUE_DEPTH];

    assign w_pop        = i_pop && (r_cnt != '0);
    assign o_item       = r_mem[r_rp];
    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            r_cnt <= r_cnt + QUEUE_CW'(i_push) - QUEUE_CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // The front end reserves a slot before it accepts, so a push always finds room.
    `SEM_ASSERT_IMP(a_push_room, i_clk, i_rst_n, i_push, r_cnt < QUEUE_CW'(QUEUE_DEPTH), "push into full queue")
    `SEM_ASSERT_IMP(a_pop_data, i_clk, i_rst_n, i_pop, r_cnt != '0, "pop from empty queue")
    `SEM_ASSERT_IMP(a_ptr_gap, i_clk, i_rst_n, 1'b1, (r_wp - r_rp) == r_cnt[QUEUE_AW-1:0], "pointer gap differs from count")

endmodule

// ===== hdl/sem_back.sv =====
// Back end: 3x3 window, Sobel gradients, squared sum and pipelined square root.
// Holds the result register seen on the output ports; uses sem_pkg.
module sem_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sem_pkg::t_q_stat            i_q_stat,
    input  sem_pkg::t_item              i_item,
    output logic                        o_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [sem_pkg::OUT_X_W-1:0] o_out_x,
    output logic [sem_pkg::OUT_Y_W-1:0] o_out_y,
    output logic [sem_pkg::MAG_W-1:0]   o_magnitude,
    output logic                        o_frame_end
);
    import sem_pkg::*;

    typedef struct packed {
        logic [OUT_X_W-1:0] out_x;
        logic [OUT_Y_W-1:0] out_y;
        logic               border;
        logic               frame_end;
    } t_meta;

    typedef struct packed {
        logic [7:0]  root;
        logic [16:0] sq;
    } t_root;

    // Four bits of a restoring square root, from bit hi downward; sq tracks root*root.
    function automatic t_root root_steps(input logic [15:0] s, input t_root start,
                                         input int hi);
        t_root       acc;
        logic [16:0] cand;
        int          bi;
        acc = start;
        for (int k = 0; k < 4; k++) begin
            bi   = hi - k;
            cand = acc.sq + (17'(acc.root) << (bi + 1)) + (17'(1) << (2 * bi));
            if (cand <= {1'b0, s}) begin
                acc.root[bi] = 1'b1;
                acc.sq       = cand;
            end
        end
        return acc;
    endfunction

    logic              w_en;
    logic [PIX_W-1:0]  r_win [9];
    logic              r_v0, r_v1, r_v2, r_v3, r_v4;
    t_meta             r_m0, r_m1, r_m2, r_m3, r_m4;
    t_meta             w_m_in;

    logic signed [11:0] w_e [9];
    logic signed [11:0] w_gx;
    logic signed [11:0] w_gy;
    logic signed [11:0] w_ax_s;
    logic signed [11:0] w_ay_s;
    logic [9:0]         r_ax;
    logic [9:0]         r_ay;
    logic [19:0]        w_ax2;
    logic [19:0]        w_ay2;
    logic [20:0]        w_sum;
    logic [15:0]        r_s2;
    logic               r_sat2;
    logic [15:0]        r_s3;
    logic               r_sat3;
    t_root              w_rt3;
    t_root              r_rt3;
    t_root              w_rt4;
    logic [MAG_W-1:0]   r_mag;

    // Advance the whole pipe unless a finished result is waiting and is not being popped.
    assign w_en  = !r_v4 || i_pop;
    assign o_pop = w_en && i_q_stat.valid;

    assign w_m_in.out_x     = i_item.out_x;
    assign w_m_in.out_y     = i_item.out_y;
    assign w_m_in.border    = i_item.border;
    assign w_m_in.frame_end = i_item.frame_end;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_e[i] = $signed({4'b0000, r_win[i]});
        end
        w_gx   = (w_e[2] - w_e[0]) + ((w_e[5] - w_e[3]) <<< 1) + (w_e[8] - w_e[6]);
        w_gy   = (w_e[0] + (w_e[1] <<< 1) + w_e[2]) - (w_e[6] + (w_e[7] <<< 1) + w_e[8]);
        w_ax_s = w_gx[11] ? -w_gx : w_gx;
        w_ay_s = w_gy[11] ? -w_gy : w_gy;
    end

    assign w_ax2 = r_ax * r_ax;
    assign w_ay2 = r_ay * r_ay;
    assign w_sum = {1'b0, w_ax2} + {1'b0, w_ay2};
    assign w_rt3 = root_steps(r_s2, '0, 7);
    assign w_rt4 = root_steps(r_s3, r_rt3, 3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (w_en) begin
            r_v0 <= i_q_stat.valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_q_stat.valid) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= i_item.up2;
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= i_item.up1;
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= i_item.pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m0   <= w_m_in;
            r_m1   <= r_m0;
            r_ax   <= w_ax_s[9:0];
            r_ay   <= w_ay_s[9:0];
            r_m2   <= r_m1;
            r_s2   <= w_sum[15:0];
            r_sat2 <= (w_sum[20:16] != '0);
            r_m3   <= r_m2;
            r_s3   <= r_s2;
            r_sat3 <= r_sat2;
            r_rt3  <= w_rt3;
            r_m4   <= r_m3;
            if (r_m3.border) begin
                r_mag <= '0;
            end else if (r_sat3) begin
                r_mag <= '1;
            end else begin
                r_mag <= w_rt4.root;
            end
        end
    end

    assign o_empty     = !r_v4;
    assign o_out_x     = r_m4.out_x;
    assign o_out_y     = r_m4.out_y;
    assign o_magnitude = r_mag;
    assign o_frame_end = r_m4.frame_end;

endmodule

// ===== hdl/sobel_edge_magnitude.sv =====
// Streaming 3x3 Sobel edge magnitude: top level.
// Instantiates sem_front, sem_queue and sem_back; uses sem_pkg.
//
// Pixels enter in raster order through a queue-style port: push/full, one
// transfer when push is high and full is low. i_frame_start marks pixel (0,0).
// Every pixel yields one result: the edge value of the pixel W+1 places
// earlier (wrapped over the frame), with its column, row and a frame_end flag.
// Results leave through empty/pop: the oldest result sits on the o_ ports while
// empty is low and transfers when pop is high.
// Sizes are written on the cfg channel (index 0 width, 1 height); the user must
// do so only while no pixel is in flight, as the block does not enforce it.
// o_cfg_ready is always high. Reset sets 1024 x 1024, clears position, window
// and pipeline; line buffer contents start unknown. Throughput: one pixel per
// cycle while full is low, set by the line buffer read in the accept cycle and
// its write-back in the next cycle (one port each). An item passes the front
// register, queue and r_v0..r_v4 before its result shows. When pop stays low
// the back end holds, the queue fills, full then rises; no result is dropped.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_cfg_ready,
    input  logic                           push,
    output logic                           full,
    input  logic [sem_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_frame_start,
    input  logic                           pop,
    output logic                           empty,
    output logic [sem_pkg::OUT_X_W-1:0]    o_out_x,
    output logic [sem_pkg::OUT_Y_W-1:0]    o_out_y,
    output logic [sem_pkg::MAG_W-1:0]      o_magnitude,
    output logic                           o_frame_end
);
    import sem_pkg::*;

    logic    w_q_push;
    t_item   w_q_in;
    logic    w_q_pop;
    t_item   w_q_out;
    t_q_stat w_q_stat;

    // Front: position tracking, line buffers, border and frame-end flags.
    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .i_push        (push),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_full        (full),
        .i_q_stat      (w_q_stat),
        .o_push        (w_q_push),
        .o_item        (w_q_in)
    );

    // Decouple front and back so either side can stall.
    sem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .i_pop   (w_q_pop),
        .o_item  (w_q_out),
        .o_stat  (w_q_stat)
    );

    // Back: window, gradients, root and the result register.
    sem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_item      (w_q_out),
        .o_pop       (w_q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_magnitude (o_magnitude),
        .o_frame_end (o_frame_end)
    );

endmodule
